// ===== rtl/cantp_pkg.sv =====
package cantp_pkg;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 96;

  localparam logic [10:0] PHYS_ID_RESET    = 11'h740;
  localparam logic [10:0] FUNC_ID_RESET    = 11'h7df;
  localparam logic [7:0]  BLOCK_SIZE_RESET = 8'd8;

  localparam logic [1:0] REG_PHYS_ID    = 2'd0;
  localparam logic [1:0] REG_FUNC_ID    = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE = 2'd2;

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;

  localparam logic [1:0] KIND_SF = 2'd0;
  localparam logic [1:0] KIND_FC = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_UNKNOWN   = 4'd1;
  localparam logic [3:0] ST_BUSY      = 4'd2;
  localparam logic [3:0] ST_BAD_LEN   = 4'd3;
  localparam logic [3:0] ST_OVERFLOW  = 4'd4;
  localparam logic [3:0] ST_WRONG_SEQ = 4'd5;
  localparam logic [3:0] ST_UNEXP     = 4'd6;
  localparam logic [3:0] ST_BAD_TYPE  = 4'd7;
  localparam logic [3:0] ST_FC        = 4'd8;

  localparam logic [1:0] FLOW_CTS = 2'd0;
  localparam logic [1:0] FLOW_OVF = 2'd2;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_SF     = 3'd1;
  localparam logic [2:0] OP_FF     = 3'd2;
  localparam logic [2:0] OP_FF_OVF = 3'd3;
  localparam logic [2:0] OP_CF     = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  status;
    logic        ch;
    logic [1:0]  kind;
    logic        show_len;
    logic [3:0]  low;
    logic [11:0] len;
    logic [55:0] data;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        channel;
    logic [1:0]  frame_kind;
    logic        clear_buffer;
    logic [11:0] write_offset;
    logic [2:0]  write_count;
    logic [55:0] write_data;
    logic        msg_complete;
    logic [11:0] msg_length;
    logic        fc_send;
    logic [1:0]  fc_status;
  } res_t;

endpackage

// ===== rtl/can_tp_rx_reassembly.sv =====
// receive side of the can transport layer, physical and functional channel
// s_* carries one received can frame per request, m_* one result per frame
// cfg_we/cfg_index/cfg_data write physical id, functional id and block size, a stmin write is ignored;
// the user must write them only while the block is idle, the block itself does not enforce it
// the front decodes id and protocol nibble and checks lengths and busy, a
// two-entry queue holds decoded frames, the back keeps per-channel length,
// count, sequence and block state and builds the result
// a frame is registered in a queue entry and then in the back's result register
// throughput: one frame per cycle while m_tready is high, as the back updates
// the channel state of each frame as it takes it
// reset: ids 0x740 and 0x7df, block size 8, both channels idle, queue and
// output register empty
// when m_tready is low the result holds, the queue fills and s_tready drops
// once both queue entries are taken
module can_tp_rx_reassembly import cantp_pkg::*; #(
  parameter int MAX_MSG_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // can_id, dlc, payload, app_busy
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status, channel, clear_buffer, write_offset, write_count, write_data,
  // msg_complete, msg_length, fc_send, fc_status
  output logic [M_TDATA_W-1:0] m_tdata,
  // frame_kind
  output logic [1:0]           m_tuser
);

  cmd_t       front_cmd;
  cmd_t       queue_cmd;
  logic       queue_valid;
  logic       queue_ready;
  logic [7:0] block_size;
  res_t       res;

  cantp_front #(
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .cmd        (front_cmd),
    .block_size (block_size)
  );

  cantp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (front_cmd),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_cmd   (queue_cmd)
  );

  cantp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (queue_valid),
    .cmd_ready  (queue_ready),
    .cmd        (queue_cmd),
    .block_size (block_size),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {3'b000, res.fc_status, res.fc_send, res.msg_length, res.msg_complete,
                    res.write_data, res.write_count, res.write_offset, res.clear_buffer,
                    res.channel, res.status};
  assign m_tuser = res.frame_kind;

endmodule

// ===== rtl/cantp_front.sv =====
module cantp_front import cantp_pkg::*; #(
  parameter int MAX_MSG_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic [S_TDATA_W-1:0] in_data,
  output cmd_t                 cmd,
  output logic [7:0]           block_size
);

  localparam logic [11:0] LEN_MAX = MAX_MSG_BYTES[11:0];

  logic [10:0] physical_id;
  logic [10:0] functional_id;

  logic [10:0] can_id;
  logic [3:0]  dlc;
  logic [63:0] payload;
  logic        app_busy;
  logic [3:0]  pci;
  logic [3:0]  low;
  logic [11:0] len;
  logic        phys_hit;
  logic        func_hit;
  logic        known;

  always_ff @(posedge clk) begin
    if (rst) begin
      physical_id   <= PHYS_ID_RESET;
      functional_id <= FUNC_ID_RESET;
      block_size    <= BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHYS_ID:    physical_id   <= cfg_data;
        REG_FUNC_ID:    functional_id <= cfg_data;
        REG_BLOCK_SIZE: block_size    <= cfg_data[7:0];
        default: ; // stmin, not used here
      endcase
    end
  end

  assign can_id   = in_data[10:0];
  assign dlc      = in_data[14:11];
  assign payload  = in_data[78:15];
  assign app_busy = in_data[79];
  assign pci      = payload[63:60];
  assign low      = payload[59:56];
  assign len      = {low, payload[55:48]};
  assign phys_hit = (can_id == physical_id);
  assign func_hit = !phys_hit && (can_id == functional_id);
  assign known    = phys_hit || func_hit;

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.status   = ST_OK;
    cmd.kind     = pci[1:0];
    cmd.low      = low;
    cmd.len      = len;
    cmd.data     = (pci == PCI_FF) ? {payload[47:0], 8'h00} : payload[55:0];
    if (pci > PCI_FC) begin
      cmd.status = ST_BAD_TYPE;
      cmd.kind   = KIND_SF;
    end else if (pci == PCI_FC) begin
      cmd.status   = ST_FC;
      cmd.ch       = func_hit;
      cmd.show_len = known;
    end else if (!known) begin
      cmd.status = ST_UNKNOWN;
    end else begin
      cmd.ch       = func_hit;
      cmd.show_len = 1'b1;
      case (pci)
        PCI_SF: begin
          if (app_busy) cmd.status = ST_BUSY;
          else if (low == 4'd0 || low >= 4'd8 || {1'b0, dlc} < ({1'b0, low} + 5'd1))
            cmd.status = ST_BAD_LEN;
          else cmd.op = OP_SF;
        end
        PCI_FF: begin
          if (func_hit) cmd.status = ST_UNEXP;
          else if (app_busy) cmd.status = ST_BUSY;
          else if (len < 12'd8) cmd.status = ST_BAD_LEN;
          else if (len > LEN_MAX) cmd.op = OP_FF_OVF;
          else cmd.op = OP_FF;
        end
        default: begin
          if (dlc < 4'd8) cmd.status = ST_BAD_LEN;
          else cmd.op = OP_CF;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cantp_queue.sv =====
module cantp_queue import cantp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/cantp_back.sv =====
module cantp_back import cantp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  input  logic [7:0] block_size,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  logic [11:0] expected_length   [2];
  logic [11:0] received_count    [2];
  logic [3:0]  sequence_expected [2];
  logic [7:0]  block_counter     [2];
  logic [1:0]  flow_state        [2];

  logic [11:0] el;
  logic [11:0] rc;
  logic [3:0]  sq;
  logic [7:0]  bc;
  logic [1:0]  fs;
  logic [11:0] el_next;
  logic [11:0] rc_next;
  logic [3:0]  sq_next;
  logic [7:0]  bc_next;
  logic [1:0]  fs_next;
  logic [11:0] diff;
  logic [2:0]  rem;
  logic [7:0]  bc_inc;
  logic        take;
  res_t        r;

  function automatic logic [55:0] byte_mask(input logic [2:0] n);
    logic [55:0] m;
    m = '0;
    for (int k = 0; k < 7; k++) begin
      if (k < int'(n)) m[55-8*k -: 8] = 8'hff;
    end
    return m;
  endfunction

  assign cmd_ready = !res_valid || res_ready;
  assign take      = cmd_valid && cmd_ready;

  assign el     = expected_length[cmd.ch];
  assign rc     = received_count[cmd.ch];
  assign sq     = sequence_expected[cmd.ch];
  assign bc     = block_counter[cmd.ch];
  assign fs     = flow_state[cmd.ch];
  assign diff   = el - rc;
  assign rem    = (diff > 12'd7) ? 3'd7 : diff[2:0];
  assign bc_inc = bc + 8'd1;

  always_comb begin
    el_next = el;
    rc_next = rc;
    sq_next = sq;
    bc_next = bc;
    fs_next = fs;
    r            = '0;
    r.status     = cmd.status;
    r.channel    = cmd.ch;
    r.frame_kind = cmd.kind;
    case (cmd.op)
      OP_SF: begin
        el_next = {8'h00, cmd.low};
        rc_next = {8'h00, cmd.low};
        sq_next = 4'd0;
        bc_next = 8'd0;
        r.clear_buffer = 1'b1;
        r.write_count  = cmd.low[2:0];
        r.msg_complete = 1'b1;
      end
      OP_FF_OVF: begin
        el_next = '0;
        rc_next = '0;
        sq_next = '0;
        bc_next = '0;
        fs_next = FLOW_OVF;
        r.status       = ST_OVERFLOW;
        r.clear_buffer = 1'b1;
        r.fc_send      = 1'b1;
        r.fc_status    = FLOW_OVF;
      end
      OP_FF: begin
        el_next = cmd.len;
        rc_next = 12'd6;
        sq_next = 4'd1;
        bc_next = 8'd0;
        fs_next = FLOW_CTS;
        r.clear_buffer = 1'b1;
        r.write_count  = 3'd6;
        r.fc_send      = 1'b1;
        r.fc_status    = FLOW_CTS;
      end
      OP_CF: begin
        if (rc >= el) begin
          r.status = ST_UNEXP;
        end else if (cmd.low != sq) begin
          el_next = '0;
          rc_next = '0;
          sq_next = '0;
          bc_next = '0;
          r.status       = ST_WRONG_SEQ;
          r.clear_buffer = 1'b1;
        end else begin
          sq_next = sq + 4'd1;
          rc_next = rc + {9'd0, rem};
          bc_next = bc_inc;
          r.write_offset = rc;
          r.write_count  = rem;
          if (rc_next == el) begin
            r.msg_complete = 1'b1;
          end else if (block_size != 8'd0 && bc_inc == block_size) begin
            bc_next     = 8'd0;
            r.fc_send   = 1'b1;
            r.fc_status = fs;
          end
        end
      end
      default: ;
    endcase
    r.write_data = cmd.data & byte_mask(r.write_count);
    r.msg_length = cmd.show_len ? el_next : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        expected_length[i]   <= '0;
        received_count[i]    <= '0;
        sequence_expected[i] <= '0;
        block_counter[i]     <= '0;
        flow_state[i]        <= FLOW_CTS;
      end
    end else if (take) begin
      expected_length[cmd.ch]   <= el_next;
      received_count[cmd.ch]    <= rc_next;
      sequence_expected[cmd.ch] <= sq_next;
      block_counter[cmd.ch]     <= bc_next;
      flow_state[cmd.ch]        <= fs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_ready) begin
      res_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= r;
    end
  end

endmodule

// ===== rtl/cantp_checker.sv =====
module cantp_checker import cantp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_bad_type_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == ST_BAD_TYPE |-> m_tdata[92:4] == '0 && m_tuser == KIND_SF)
    else $error("bad type result carries data");

  a_fc_status_gated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[90] |-> m_tdata[92:91] == 2'b00)
    else $error("flow status without flow control request");

  a_complete_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[77] |-> m_tdata[3:0] == ST_OK && m_tdata[20:18] != 3'd0)
    else $error("completion without accepted bytes");

endmodule

bind can_tp_rx_reassembly cantp_checker u_cantp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== test/can_tp_rx_reassembly_tb.sv =====
`timescale 1ns / 100ps

module can_tp_rx_reassembly_tb;
  import cantp_pkg::*;

  localparam int MAX_MSG_BYTES = 1024;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_FRAMES = 340;
  localparam logic [1:0] REG_STMIN = 2'd3;
  localparam logic [7:0] STMIN_RESET = 8'd20;
  localparam logic [1:0] KIND_FF = 2'd1;
  localparam logic [1:0] KIND_CF = 2'd2;

  typedef struct packed {
    logic        busy;
    logic [63:0] payload;
    logic [3:0]  dlc;
    logic [10:0] can_id;
  } can_frame_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [1:0]  fc_status;
    logic        fc_send;
    logic [11:0] msg_length;
    logic        msg_complete;
    logic [55:0] write_data;
    logic [2:0]  write_count;
    logic [11:0] write_offset;
    logic        clear_buffer;
    logic        channel;
    logic [3:0]  status;
  } result_word_t;

  typedef struct {
    can_frame_t f;
    bit         typed;
    res_t       r;
  } vector_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [10:0]          cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;

  // predictor copy of registers and per-channel state
  logic [10:0] cfg_phys, cfg_func;
  logic [7:0]  cfg_bs, cfg_stmin;
  logic [11:0] chan_len[2];
  logic [11:0] chan_rcvd[2];
  logic [3:0]  chan_sn[2];
  logic [7:0]  chan_blk[2];
  logic [1:0]  chan_flow[2];

  res_t          pending_results[$];
  can_frame_t    frame_q[$];
  vector_row_t   directed_rows[$];
  int            cycles = 0;
  int            n_frames = 0, n_results = 0, n_errors = 0;
  int            n_complete = 0, n_fc = 0, n_ovf = 0, n_seq = 0;
  int            burst_left = 0;
  int            rx_mode = 0;
  result_word_t  rx_word;
  res_t          rx_got, rx_exp;
  string         rx_diff;

  can_tp_rx_reassembly #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [55:0] pick_bytes(logic [63:0] pl, int start, int cnt);
    logic [63:0] v, mask;
    if (cnt == 0 || cnt > 7) return '0;
    v = (pl << (8 * start)) >> 8;
    mask = ((64'd1 << (8 * cnt)) - 64'd1) << (8 * (7 - cnt));
    return v[55:0] & mask[55:0];
  endfunction

  function automatic void clear_chan(int ch);
    chan_len[ch] = '0;
    chan_rcvd[ch] = '0;
    chan_sn[ch] = '0;
    chan_blk[ch] = '0;
  endfunction

  function automatic res_t reassemble_frame(can_frame_t f);
    res_t        r;
    logic [7:0]  b0, b1;
    logic [3:0]  pci, low;
    logic [11:0] len, rem;
    bit          known;
    int          ch;
    r = '0;
    b0 = f.payload[63:56];
    b1 = f.payload[55:48];
    pci = b0[7:4];
    low = b0[3:0];
    known = 1'b1;
    ch = 0;
    if (f.can_id == cfg_phys) ch = 0;
    else if (f.can_id == cfg_func) ch = 1;
    else known = 1'b0;

    if (pci > PCI_FC) begin
      r.status = ST_BAD_TYPE;
    end else if (pci == PCI_FC) begin
      r.status = ST_FC;
      r.frame_kind = KIND_FC;
      if (known) begin
        r.channel = ch[0];
        r.msg_length = chan_len[ch];
      end
    end else if (!known) begin
      r.status = ST_UNKNOWN;
      r.frame_kind = pci[1:0];
    end else begin
      r.channel = ch[0];
      r.frame_kind = pci[1:0];
      if (pci == PCI_SF) begin
        if (f.busy) r.status = ST_BUSY;
        else if (low == 0 || low >= 8 || int'(f.dlc) < int'(low) + 1) r.status = ST_BAD_LEN;
        else begin
          clear_chan(ch);
          chan_len[ch] = 12'(low);
          chan_rcvd[ch] = 12'(low);
          r.clear_buffer = 1'b1;
          r.write_count = low[2:0];
          r.write_data = pick_bytes(f.payload, 1, int'(low));
          r.msg_complete = 1'b1;
        end
      end else if (pci == PCI_FF) begin
        len = {low, b1};
        if (ch != 0) r.status = ST_UNEXP;
        else if (f.busy) r.status = ST_BUSY;
        else if (len < 8) r.status = ST_BAD_LEN;
        else if (len > MAX_MSG_BYTES) begin
          clear_chan(ch);
          chan_flow[ch] = FLOW_OVF;
          r.status = ST_OVERFLOW;
          r.clear_buffer = 1'b1;
          r.fc_send = 1'b1;
          r.fc_status = FLOW_OVF;
        end else begin
          clear_chan(ch);
          chan_flow[ch] = FLOW_CTS;
          chan_len[ch] = len;
          chan_rcvd[ch] = 12'd6;
          chan_sn[ch] = 4'd1;
          r.clear_buffer = 1'b1;
          r.write_count = 3'd6;
          r.write_data = pick_bytes(f.payload, 2, 6);
          r.fc_send = 1'b1;
          r.fc_status = chan_flow[ch];
        end
      end else begin
        if (f.dlc < 8) r.status = ST_BAD_LEN;
        else if (chan_rcvd[ch] >= chan_len[ch]) r.status = ST_UNEXP;
        else if (low != chan_sn[ch]) begin
          clear_chan(ch);
          r.status = ST_WRONG_SEQ;
          r.clear_buffer = 1'b1;
        end else begin
          rem = chan_len[ch] - chan_rcvd[ch];
          if (rem > 7) rem = 12'd7;
          chan_sn[ch] = chan_sn[ch] + 4'd1;
          r.write_offset = chan_rcvd[ch];
          r.write_count = rem[2:0];
          r.write_data = pick_bytes(f.payload, 1, int'(rem));
          chan_rcvd[ch] = chan_rcvd[ch] + rem;
          chan_blk[ch] = chan_blk[ch] + 8'd1;
          if (chan_rcvd[ch] == chan_len[ch]) r.msg_complete = 1'b1;
          else if (cfg_bs != 0 && chan_blk[ch] == cfg_bs) begin
            chan_blk[ch] = '0;
            r.fc_send = 1'b1;
            r.fc_status = chan_flow[ch];
          end
        end
      end
      r.msg_length = chan_len[ch];
    end
    return r;
  endfunction

  function automatic res_t exp_of(logic [3:0] st, logic ch, logic [1:0] kind, logic clr,
                                  logic fcs, logic [1:0] fcv, logic [11:0] mlen);
    res_t r;
    r = '0;
    r.status = st;
    r.channel = ch;
    r.frame_kind = kind;
    r.clear_buffer = clr;
    r.fc_send = fcs;
    r.fc_status = fcv;
    r.msg_length = mlen;
    return r;
  endfunction

  function automatic string fmt(res_t r);
    return $sformatf("st=%0d ch=%0d k=%0d clr=%0d off=%0d n=%0d d=%h done=%0d len=%0d fc=%0d/%0d",
                     r.status, r.channel, r.frame_kind, r.clear_buffer, r.write_offset,
                     r.write_count, r.write_data, r.msg_complete, r.msg_length, r.fc_send,
                     r.fc_status);
  endfunction

  function automatic string diff_fields(res_t e, res_t a);
    string s;
    s = "";
    if (e.status !== a.status) s = {s, " status"};
    if (e.channel !== a.channel) s = {s, " channel"};
    if (e.frame_kind !== a.frame_kind) s = {s, " frame_kind"};
    if (e.clear_buffer !== a.clear_buffer) s = {s, " clear_buffer"};
    if (e.write_offset !== a.write_offset) s = {s, " write_offset"};
    if (e.write_count !== a.write_count) s = {s, " write_count"};
    if (e.write_data !== a.write_data) s = {s, " write_data"};
    if (e.msg_complete !== a.msg_complete) s = {s, " msg_complete"};
    if (e.msg_length !== a.msg_length) s = {s, " msg_length"};
    if (e.fc_send !== a.fc_send) s = {s, " fc_send"};
    if (e.fc_status !== a.fc_status) s = {s, " fc_status"};
    return s;
  endfunction

  // receiver stalls, with the stall pattern picked at random from four modes
  always @(posedge clk) begin
    if (cycles % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (cycles % 8) < 5;
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rx_word = result_word_t'(m_tdata);
      rx_got = '0;
      rx_got.status = rx_word.status;
      rx_got.channel = rx_word.channel;
      rx_got.frame_kind = m_tuser;
      rx_got.clear_buffer = rx_word.clear_buffer;
      rx_got.write_offset = rx_word.write_offset;
      rx_got.write_count = rx_word.write_count;
      rx_got.write_data = rx_word.write_data;
      rx_got.msg_complete = rx_word.msg_complete;
      rx_got.msg_length = rx_word.msg_length;
      rx_got.fc_send = rx_word.fc_send;
      rx_got.fc_status = rx_word.fc_status;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("result with no request pending: %s", fmt(rx_got));
      end else begin
        rx_exp = pending_results.pop_front();
        rx_diff = diff_fields(rx_exp, rx_got);
        if (rx_diff != "") begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("result %0d differs in%s", n_results, rx_diff);
            $display("  exp %s", fmt(rx_exp));
            $display("  got %s", fmt(rx_got));
          end
        end
        n_complete += rx_exp.msg_complete;
        n_fc += rx_exp.fc_send;
        if (rx_exp.status == ST_OVERFLOW) n_ovf++;
        if (rx_exp.status == ST_WRONG_SEQ) n_seq++;
      end
      n_results++;
    end
  end

  task automatic send_frame(can_frame_t f, bit typed, res_t r);
    int   gap;
    res_t e;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e = reassemble_frame(f);
    if (typed) e = r;
    pending_results.push_back(e);
    n_frames++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [10:0] phys, logic [10:0] func, logic [7:0] bs,
                          logic [7:0] stm);
    cfg_we <= 1'b1;
    cfg_index <= REG_PHYS_ID;
    cfg_data <= phys;
    cfg_phys = phys;
    @(posedge clk);
    cfg_index <= REG_FUNC_ID;
    cfg_data <= func;
    cfg_func = func;
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data <= 11'(bs);
    cfg_bs = bs;
    @(posedge clk);
    cfg_index <= REG_STMIN;
    cfg_data <= 11'(stm);
    cfg_stmin = stm;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_vec(logic [10:0] id, logic [3:0] dlc, logic [63:0] pl, logic busy,
                         bit typed, res_t r);
    vector_row_t v;
    v.f.can_id = id;
    v.f.dlc = dlc;
    v.f.payload = pl;
    v.f.busy = busy;
    v.typed = typed;
    v.r = r;
    directed_rows.push_back(v);
  endtask

  task automatic gen_single();
    can_frame_t f;
    int         low;
    f.can_id = $urandom_range(0, 1) ? cfg_phys : cfg_func;
    f.busy = ($urandom_range(0, 9) == 0);
    f.payload = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      low = $urandom_range(0, 15);
      f.dlc = 4'($urandom_range(0, 15));
    end else begin
      low = $urandom_range(1, 7);
      f.dlc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(low + 1, 15)) : 4'd8;
    end
    f.payload[63:56] = {PCI_SF, 4'(low)};
    frame_q.push_back(f);
  endtask

  task automatic gen_flow_ctl();
    can_frame_t f;
    case ($urandom_range(0, 2))
      0: f.can_id = cfg_phys;
      1: f.can_id = cfg_func;
      default: f.can_id = 11'($urandom_range(0, 2047));
    endcase
    f.dlc = 4'($urandom_range(0, 15));
    f.busy = 1'($urandom_range(0, 1));
    f.payload = {$urandom, $urandom};
    f.payload[63:60] = PCI_FC;
    frame_q.push_back(f);
  endtask

  task automatic gen_noise();
    can_frame_t f;
    case ($urandom_range(0, 2))
      0: f.can_id = cfg_phys;
      1: f.can_id = cfg_func;
      default: f.can_id = 11'($urandom_range(0, 2047));
    endcase
    f.dlc = 4'($urandom_range(0, 15));
    f.busy = 1'($urandom_range(0, 1));
    f.payload = {$urandom, $urandom};
    frame_q.push_back(f);
  endtask

  task automatic gen_side();
    case ($urandom_range(0, 2))
      0: gen_single();
      1: gen_flow_ctl();
      default: gen_noise();
    endcase
  endtask

  // first frame on the physical id followed by its consecutive frames, with side frames mixed in
  task automatic gen_message();
    can_frame_t f;
    int         len, ncf, sn, k;
    case ($urandom_range(0, 19))
      0: len = $urandom_range(0, 7);
      1: len = $urandom_range(MAX_MSG_BYTES + 1, 4095);
      2, 3: len = $urandom_range(121, MAX_MSG_BYTES);
      default: len = $urandom_range(8, 120);
    endcase
    f.can_id = cfg_phys;
    f.dlc = 4'd8;
    f.busy = ($urandom_range(0, 19) == 0);
    f.payload = {$urandom, $urandom};
    f.payload[63:48] = {PCI_FF, 12'(len)};
    frame_q.push_back(f);
    ncf = (len >= 8 && len <= MAX_MSG_BYTES) ? len / 7 : $urandom_range(0, 2);
    sn = 1;
    for (k = 0; k < ncf; k++) begin
      f.busy = ($urandom_range(0, 15) == 0);
      f.dlc = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      f.payload = {$urandom, $urandom};
      f.payload[63:56] = {PCI_CF, 4'(sn)};
      if ($urandom_range(0, 59) == 0) f.payload[59:56] = 4'(sn + $urandom_range(1, 15));
      frame_q.push_back(f);
      if ($urandom_range(0, 24) == 0) gen_side();
      sn = (sn + 1) % 16;
    end
  endtask

  task automatic run_phase(bit mid_pause);
    int k;
    while (frame_q.size() < PHASE_FRAMES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 8, 9: gen_message();
        4, 5: gen_single();
        6: gen_flow_ctl();
        default: gen_noise();
      endcase
    end
    k = 0;
    while (frame_q.size() != 0) begin
      if (mid_pause && k == PHASE_FRAMES / 2) wait_idle();
      send_frame(frame_q.pop_front(), 1'b0, '0);
      k++;
    end
    wait_idle();
  endtask

  initial begin
    cfg_phys = PHYS_ID_RESET;
    cfg_func = FUNC_ID_RESET;
    cfg_bs = BLOCK_SIZE_RESET;
    cfg_stmin = STMIN_RESET;
    for (int i = 0; i < 2; i++) begin
      clear_chan(i);
      chan_flow[i] = FLOW_CTS;
    end

    // rejects and extremes after reset
    add_vec(PHYS_ID_RESET, 4'd8, 64'h4F00_0000_0000_0000, 1'b0, 1'b1,
            exp_of(ST_BAD_TYPE, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
            exp_of(ST_BAD_TYPE, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(11'h000, 4'd8, 64'h0311_2233_0000_0000, 1'b0, 1'b1,
            exp_of(ST_UNKNOWN, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd8, 64'h03AA_BBCC_0000_0000, 1'b1, 1'b1,
            exp_of(ST_BUSY, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd8, 64'h0000_0000_0000_0000, 1'b0, 1'b1,
            exp_of(ST_BAD_LEN, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd8, 64'h0801_0203_0405_0607, 1'b0, 1'b1,
            exp_of(ST_BAD_LEN, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd1, 64'h0155_0000_0000_0000, 1'b0, 1'b1,
            exp_of(ST_BAD_LEN, 1'b0, KIND_SF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd8, 64'h07FF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd8, 64'h2111_2233_4455_6677, 1'b0, 1'b1,
            exp_of(ST_UNEXP, 1'b0, KIND_CF, 1'b0, 1'b0, FLOW_CTS, 12'd7));
    add_vec(FUNC_ID_RESET, 4'd8, 64'h1014_0102_0304_0506, 1'b0, 1'b1,
            exp_of(ST_UNEXP, 1'b1, KIND_FF, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd8, 64'h1007_0102_0304_0506, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd8, 64'h1FFF_0102_0304_0506, 1'b0, 1'b1,
            exp_of(ST_OVERFLOW, 1'b0, KIND_FF, 1'b1, 1'b1, FLOW_OVF, 12'd0));
    add_vec(PHYS_ID_RESET, 4'd8, 64'h1401_0102_0304_0506, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd8, 64'h1400_A1A2_A3A4_A5A6, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd7, 64'h21B1_B2B3_B4B5_B6B7, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd8, 64'h22C1_C2C3_C4C5_C6C7, 1'b0, 1'b0, '0);
    // complete message of 27 bytes, last frame with dlc above 8
    add_vec(PHYS_ID_RESET, 4'd8, 64'h101B_0102_0304_0506, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd8, 64'h2107_0809_0A0B_0C0D, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd8, 64'h220E_0F10_1112_1314, 1'b0, 1'b0, '0);
    add_vec(PHYS_ID_RESET, 4'd15, 64'h2315_1617_1819_1A1B, 1'b0, 1'b0, '0);
    add_vec(11'h555, 4'd0, 64'h3000_0000_0000_0000, 1'b0, 1'b1,
            exp_of(ST_FC, 1'b0, KIND_FC, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(FUNC_ID_RESET, 4'd3, 64'h3F08_1400_0000_0000, 1'b1, 1'b1,
            exp_of(ST_FC, 1'b1, KIND_FC, 1'b0, 1'b0, FLOW_CTS, 12'd0));
    add_vec(FUNC_ID_RESET, 4'd4, 64'h03DE_ADBE_EF00_0000, 1'b0, 1'b0, '0);
    add_vec(FUNC_ID_RESET, 4'd8, 64'h2101_0203_0405_0607, 1'b0, 1'b0, '0);
    add_vec(11'h2AA, 4'd8, 64'h1020_0102_0304_0506, 1'b0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_frame(directed_rows[i].f, directed_rows[i].typed, directed_rows[i].r);
    wait_idle();

    set_regs(11'h000, 11'h7FF, 8'd1, 8'd0);
    run_phase(1'b0);
    set_regs(11'h7FF, 11'h000, 8'd255, 8'd255);
    run_phase(1'b0);
    // equal ids, physical channel takes all; block size zero never asks after a consecutive frame
    set_regs(11'h123, 11'h123, 8'd0, 8'd7);
    run_phase(1'b0);
    set_regs(PHYS_ID_RESET, FUNC_ID_RESET, 8'd3, STMIN_RESET);
    run_phase(1'b1);
    set_regs(11'h100 + 11'($urandom_range(0, 255)), 11'h600 + 11'($urandom_range(0, 255)),
             8'($urandom_range(1, 16)), 8'($urandom_range(0, 255)));
    run_phase(1'b0);

    $display("%0d frames in, %0d results checked, %0d errors", n_frames, n_results, n_errors);
    $display("%0d messages completed, %0d fc requests, %0d overflows, %0d sequence breaks",
             n_complete, n_fc, n_ovf, n_seq);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cantp_pkg.sv
rtl/cantp_front.sv
rtl/cantp_queue.sv
rtl/cantp_back.sv
rtl/can_tp_rx_reassembly.sv
rtl/cantp_checker.sv
test/can_tp_rx_reassembly_tb.sv
